[rtl/hid_report_descriptor_parser_top_defines.svh]
// Assertion macros shared by the HID descriptor parser modules.
// Depends on clk and arst_n being visible at the point of use.
`ifndef HID_REPORT_DESCRIPTOR_PARSER_TOP_DEFINES_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HRDP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrdp: implication check failed");
`define HRDP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hrdp: next-cycle check failed");
`else
`define HRDP_ASSERT_IMP(lbl, ante, cons)
`define HRDP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/hrdp_pkg.sv]
// Types and constants for the HID report descriptor parser.
// Used by hrdp_ctrl, hrdp_dp and the top level; no dependencies.
package hrdp_pkg;

	localparam logic [3:0] KIND_HEADER     = 4'd0;
	localparam logic [3:0] KIND_USAGE      = 4'd1;
	localparam logic [3:0] KIND_DONE       = 4'd2;
	localparam logic [3:0] ERR_LONG        = 4'd3;
	localparam logic [3:0] ERR_RESERVED    = 4'd4;
	localparam logic [3:0] ERR_TRUNC       = 4'd5;
	localparam logic [3:0] ERR_NEST        = 4'd6;
	localparam logic [3:0] ERR_END_COLL    = 4'd7;
	localparam logic [3:0] ERR_MAIN_TAG    = 4'd8;
	localparam logic [3:0] ERR_USAGES      = 4'd9;
	localparam logic [3:0] ERR_RANGE       = 4'd10;
	localparam logic [3:0] ERR_LOCAL_TAG   = 4'd11;
	localparam logic [3:0] ERR_PUSH_POP    = 4'd12;
	localparam logic [3:0] ERR_GLOBAL_TAG  = 4'd13;
	localparam logic [3:0] ERR_REPORTS     = 4'd14;

	localparam logic [1:0] TYPE_MAIN   = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL = 2'd1;
	localparam logic [1:0] TYPE_LOCAL  = 2'd2;

	localparam logic [5:0] TAG_INPUT    = 6'h20;
	localparam logic [5:0] TAG_OUTPUT   = 6'h24;
	localparam logic [5:0] TAG_COLL     = 6'h28;
	localparam logic [5:0] TAG_END_COLL = 6'h30;
	localparam logic [5:0] TAG_PAGE     = 6'h01;
	localparam logic [5:0] TAG_LMIN     = 6'h05;
	localparam logic [5:0] TAG_LMAX     = 6'h09;
	localparam logic [5:0] TAG_PMIN     = 6'h0D;
	localparam logic [5:0] TAG_PMAX     = 6'h11;
	localparam logic [5:0] TAG_UEXP     = 6'h15;
	localparam logic [5:0] TAG_UNIT     = 6'h19;
	localparam logic [5:0] TAG_SIZE     = 6'h1D;
	localparam logic [5:0] TAG_RID      = 6'h21;
	localparam logic [5:0] TAG_COUNT    = 6'h25;
	localparam logic [5:0] TAG_PUSH     = 6'h29;
	localparam logic [5:0] TAG_POP      = 6'h2D;
	localparam logic [5:0] TAG_USAGE    = 6'h02;
	localparam logic [5:0] TAG_UMIN     = 6'h06;
	localparam logic [5:0] TAG_UMAX     = 6'h0A;

	localparam logic [3:0] PREFIX_LONG = 4'hF;
	localparam logic [1:0] SIZE_FOUR   = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE, OP_START, OP_BYTE, OP_EXEC, OP_POP, OP_RANGE, OP_SRD, OP_SCMP,
		OP_MUL, OP_ADD, OP_HDR, OP_URD, OP_UEM, OP_FIN
	} op_t;

	typedef enum logic [1:0] {NX_FIN, NX_POP, NX_SRCH, NX_RANGE} next_t;

	typedef struct packed {
		logic load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic  latched;
		logic  complete;
		next_t exec_next;
		logic  range_done;
		logic  srch_end;
		logic  rep_full;
		logic  id_match;
		logic  has_usages;
		logic  usg_last;
		logic  out_free;
	} status_t;

	function automatic logic [2:0] item_len(input logic [7:0] p);
		logic [2:0] l;
		l = (p[1:0] == SIZE_FOUR) ? 3'd4 : {1'b0, p[1:0]};
		return l;
	endfunction

endpackage

[rtl/hid_report_descriptor_parser_top.sv]
// HID report descriptor parser: one descriptor byte per transfer in, field
// headers, usages, done and error codes out. A byte is taken only when the
// previous byte is finished: each byte passes START and BYTE, then EXEC if it
// completes an item, then FIN; one after a sticky error returns to IDLE from
// BYTE. An Input item walks the report table (SRD and SCMP per known report
// ID compared), then MUL and ADD and, if usages are held, the header and one
// transfer per usage; a usage range stays in RANGE until filled, and an End
// Collection adds POP. Result transfers stall the sequencer while the output
// is held. Depends on hrdp_pkg, hrdp_ctrl and hrdp_dp.
module hid_report_descriptor_parser_top
	import hrdp_pkg::*;
#(
	parameter int MAX_USAGES  = 32,
	parameter int MAX_NESTING = 16,
	parameter int MAX_REPORTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               desc_valid,
	output logic               desc_stall,
	input  logic [7:0]         desc_byte,
	input  logic               first_byte,
	input  logic               last_byte,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [3:0]         result_kind,
	output logic [7:0]         rpt_id,
	output logic [23:0]        bit_offset,
	output logic [15:0]        field_size,
	output logic [15:0]        field_count,
	output logic signed [31:0] logical_min,
	output logic signed [31:0] logical_max,
	output logic signed [31:0] physical_min,
	output logic signed [31:0] physical_max,
	output logic [31:0]        unit_code,
	output logic [15:0]        usage,
	output logic               last
);

	cmd_t    cmd;
	status_t status;

	hrdp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_stall (desc_stall),
		.status     (status),
		.cmd        (cmd)
	);

	hrdp_dp #(
		.MAX_USAGES  (MAX_USAGES),
		.MAX_NESTING (MAX_NESTING),
		.MAX_REPORTS (MAX_REPORTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.desc_byte    (desc_byte),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_kind  (result_kind),
		.rpt_id       (rpt_id),
		.bit_offset   (bit_offset),
		.field_size   (field_size),
		.field_count  (field_count),
		.logical_min  (logical_min),
		.logical_max  (logical_max),
		.physical_min (physical_min),
		.physical_max (physical_max),
		.unit_code    (unit_code),
		.usage        (usage),
		.last         (last)
	);

endmodule

[rtl/hrdp_dp.sv]
// Datapath of the HID descriptor parser: item assembly, global/local state,
// usage, nesting and report tables, and the result register. Uses hrdp_pkg.
`include "hid_report_descriptor_parser_top_defines.svh"
module hrdp_dp
	import hrdp_pkg::*;
#(
	parameter int MAX_USAGES  = 32,
	parameter int MAX_NESTING = 16,
	parameter int MAX_REPORTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [7:0]         desc_byte,
	input  logic               first_byte,
	input  logic               last_byte,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [3:0]         result_kind,
	output logic [7:0]         rpt_id,
	output logic [23:0]        bit_offset,
	output logic [15:0]        field_size,
	output logic [15:0]        field_count,
	output logic signed [31:0] logical_min,
	output logic signed [31:0] logical_max,
	output logic signed [31:0] physical_min,
	output logic signed [31:0] physical_max,
	output logic [31:0]        unit_code,
	output logic [15:0]        usage,
	output logic               last
);

	localparam int UF_W = $clog2(MAX_USAGES + 1);
	localparam int UA_W = $clog2(MAX_USAGES);
	localparam int NC_W = $clog2(MAX_NESTING + 1);
	localparam int NA_W = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
	localparam int RC_W = $clog2(MAX_REPORTS + 1);
	localparam int RA_W = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;

	logic [7:0]      byte_q;
	logic            first_q;
	logic            last_q;
	logic [2:0]      phase_q;
	logic [7:0]      prefix_q;
	logic [31:0]     data_q;
	logic [7:0]      page_q;
	logic [7:0]      rid_q;
	logic [15:0]     size_q;
	logic [15:0]     count_q;
	logic [31:0]     lim_q [4];
	logic [31:0]     unit_q;
	logic [UF_W-1:0] fill_q;
	logic [15:0]     rmin_q;
	logic [NA_W:0]   open_q;
	logic [NC_W-1:0] coll_used_q;
	logic [RC_W-1:0] rep_used_q;
	logic            err_latched_q;
	logic            err_v_q;
	logic [3:0]      err_q;
	logic [16:0]     rv_q;
	logic [15:0]     rmax_q;
	logic [RC_W-1:0] si_q;
	logic [RA_W-1:0] ridx_q;
	logic [23:0]     offset_q;
	logic [31:0]     prod_q;
	logic [UF_W-1:0] ucnt_q;
	logic [UF_W-1:0] ui_q;

	logic [15:0]     usage_mem [MAX_USAGES];
	logic [15:0]     usage_rd_q;
	logic [NA_W:0]   parent_mem [MAX_NESTING];
	logic [NA_W:0]   parent_rd_q;
	logic [31:0]     rep_mem [MAX_REPORTS];
	logic [31:0]     rep_rd_q;

	logic [2:0]      plen;
	logic [5:0]      tag;
	logic [1:0]      itype;
	logic [31:0]     sval;
	logic            perr;
	logic [1:0]      bidx;
	logic [UF_W-1:0] uj;
	logic [16:0]     cmax;
	logic [UF_W-1:0] cnt;
	logic            fin_err;
	logic            out_free;

	assign plen  = item_len(prefix_q);
	assign tag   = prefix_q[7:2];
	assign itype = tag[1:0];
	assign perr  = (byte_q[7:4] == PREFIX_LONG) || (byte_q[3:2] == SIZE_FOUR);
	assign bidx  = 2'(plen - phase_q);
	assign uj    = (ui_q < fill_q) ? ui_q : fill_q - UF_W'(1);
	assign cmax  = ({1'b0, count_q} > 17'(fill_q)) ? {1'b0, count_q} : 17'(fill_q);
	assign cnt   = (cmax > 17'(MAX_USAGES)) ? UF_W'(MAX_USAGES) : cmax[UF_W-1:0];
	assign fin_err = err_v_q || (last_q && (phase_q != 3'd0));
	assign out_free = !res_valid || !res_stall;

	always_comb begin
		unique case (plen)
			3'd1:    sval = {{24{data_q[7]}}, data_q[7:0]};
			3'd2:    sval = {{16{data_q[15]}}, data_q[15:0]};
			3'd4:    sval = data_q;
			default: sval = 32'd0;
		endcase
	end

	always_comb begin
		status.latched    = err_latched_q;
		status.complete   = (phase_q == 3'd0) ? (!perr && (byte_q[1:0] == 2'd0))
			: (phase_q == 3'd1);
		status.exec_next  = NX_FIN;
		if (itype == TYPE_MAIN && page_q != 8'd0 && tag == TAG_INPUT)
			status.exec_next = NX_SRCH;
		else if (itype == TYPE_MAIN && page_q != 8'd0 && tag == TAG_END_COLL && open_q[NA_W])
			status.exec_next = NX_POP;
		else if (tag == TAG_UMAX && fill_q == '0)
			status.exec_next = NX_RANGE;
		status.range_done = (rv_q > {1'b0, rmax_q}) || (fill_q >= UF_W'(MAX_USAGES));
		status.srch_end   = (si_q == rep_used_q);
		status.rep_full   = (rep_used_q == RC_W'(MAX_REPORTS));
		status.id_match   = (rep_rd_q[31:24] == rid_q);
		status.has_usages = (fill_q != '0);
		status.usg_last   = (ui_q == ucnt_q - UF_W'(1));
		status.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if ((cmd.op == OP_EXEC && tag == TAG_USAGE && fill_q < UF_W'(MAX_USAGES - 1))
				|| (cmd.op == OP_RANGE && !status.range_done)) begin
			usage_mem[fill_q[UA_W-1:0]] <= (cmd.op == OP_RANGE) ? rv_q[15:0] : data_q[15:0];
		end
		usage_rd_q <= usage_mem[uj[UA_W-1:0]];
		if (cmd.op == OP_EXEC && itype == TYPE_MAIN && page_q != 8'd0 && tag == TAG_COLL
				&& coll_used_q < NC_W'(MAX_NESTING)) begin
			parent_mem[coll_used_q[NA_W-1:0]] <= open_q;
		end
		parent_rd_q <= parent_mem[open_q[NA_W-1:0]];
		if (cmd.op == OP_SRD && status.srch_end && !status.rep_full)
			rep_mem[si_q[RA_W-1:0]] <= {rid_q, 24'd0};
		else if (cmd.op == OP_ADD)
			rep_mem[ridx_q] <= {rid_q, offset_q + prod_q[23:0]};
		rep_rd_q <= rep_mem[si_q[RA_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q        <= '0;
			first_q       <= 1'b0;
			last_q        <= 1'b0;
			phase_q       <= '0;
			prefix_q      <= '0;
			data_q        <= '0;
			page_q        <= '0;
			rid_q         <= '0;
			size_q        <= '0;
			count_q       <= '0;
			lim_q         <= '{default: '0};
			unit_q        <= '0;
			fill_q        <= '0;
			rmin_q        <= '0;
			open_q        <= '0;
			coll_used_q   <= '0;
			rep_used_q    <= '0;
			err_latched_q <= 1'b0;
			err_v_q       <= 1'b0;
			err_q         <= '0;
			rv_q          <= '0;
			rmax_q        <= '0;
			si_q          <= '0;
			ridx_q        <= '0;
			offset_q      <= '0;
			prod_q        <= '0;
			ucnt_q        <= '0;
			ui_q          <= '0;
			res_valid     <= 1'b0;
			result_kind   <= '0;
			rpt_id        <= '0;
			bit_offset    <= '0;
			field_size    <= '0;
			field_count   <= '0;
			logical_min   <= '0;
			logical_max   <= '0;
			physical_min  <= '0;
			physical_max  <= '0;
			unit_code     <= '0;
			usage         <= '0;
			last          <= 1'b0;
		end else begin
			if (res_valid && !res_stall)
				res_valid <= 1'b0;
			if (cmd.load) begin
				byte_q  <= desc_byte;
				first_q <= first_byte;
				last_q  <= last_byte;
			end
			unique case (cmd.op)
				OP_START: begin
					err_v_q <= 1'b0;
					if (first_q) begin
						phase_q       <= '0;
						prefix_q      <= '0;
						data_q        <= '0;
						page_q        <= '0;
						rid_q         <= '0;
						size_q        <= '0;
						count_q       <= '0;
						lim_q         <= '{default: '0};
						unit_q        <= '0;
						fill_q        <= '0;
						rmin_q        <= '0;
						open_q        <= '0;
						coll_used_q   <= '0;
						rep_used_q    <= '0;
						err_latched_q <= 1'b0;
					end
				end
				OP_BYTE: begin
					if (phase_q == 3'd0) begin
						prefix_q <= byte_q;
						data_q   <= '0;
						if (byte_q[7:4] == PREFIX_LONG) begin
							err_v_q <= 1'b1;
							err_q   <= ERR_LONG;
						end else if (byte_q[3:2] == SIZE_FOUR) begin
							err_v_q <= 1'b1;
							err_q   <= ERR_RESERVED;
						end else begin
							phase_q <= item_len(byte_q);
						end
					end else begin
						unique case (bidx)
							2'd0: data_q[7:0]   <= byte_q;
							2'd1: data_q[15:8]  <= byte_q;
							2'd2: data_q[23:16] <= byte_q;
							2'd3: data_q[31:24] <= byte_q;
						endcase
						phase_q <= phase_q - 3'd1;
					end
				end
				OP_EXEC: begin
					unique case (itype)
						TYPE_MAIN: begin
							if (page_q != 8'd0) begin
								priority case (tag)
									TAG_COLL: begin
										if (coll_used_q >= NC_W'(MAX_NESTING)) begin
											err_v_q <= 1'b1;
											err_q   <= ERR_NEST;
										end else begin
											open_q      <= {1'b1, coll_used_q[NA_W-1:0]};
											coll_used_q <= coll_used_q + NC_W'(1);
											rid_q       <= '0;
											size_q      <= '0;
											count_q     <= '0;
											lim_q       <= '{default: '0};
											unit_q      <= '0;
											fill_q      <= '0;
											rmin_q      <= '0;
										end
									end
									TAG_END_COLL: begin
										if (!open_q[NA_W]) begin
											err_v_q <= 1'b1;
											err_q   <= ERR_END_COLL;
										end
									end
									TAG_INPUT:  si_q <= '0;
									TAG_OUTPUT: ;
									default: begin
										fill_q  <= '0;
										err_v_q <= 1'b1;
										err_q   <= ERR_MAIN_TAG;
									end
								endcase
							end
						end
						TYPE_GLOBAL: begin
							priority case (tag)
								TAG_PAGE:  page_q   <= data_q[7:0];
								TAG_PUSH, TAG_POP: begin
									err_v_q <= 1'b1;
									err_q   <= ERR_PUSH_POP;
								end
								TAG_LMIN:  lim_q[0] <= sval;
								TAG_LMAX:  lim_q[1] <= sval;
								TAG_PMIN:  lim_q[2] <= sval;
								TAG_PMAX:  lim_q[3] <= sval;
								TAG_UEXP:  ;
								TAG_UNIT:  unit_q   <= data_q;
								TAG_SIZE:  size_q   <= data_q[15:0];
								TAG_COUNT: count_q  <= data_q[15:0];
								TAG_RID:   rid_q    <= data_q[7:0];
								default: begin
									err_v_q <= 1'b1;
									err_q   <= ERR_GLOBAL_TAG;
								end
							endcase
						end
						TYPE_LOCAL: begin
							priority case (tag)
								TAG_USAGE: begin
									if (fill_q >= UF_W'(MAX_USAGES - 1)) begin
										err_v_q <= 1'b1;
										err_q   <= ERR_USAGES;
									end else begin
										fill_q <= fill_q + UF_W'(1);
									end
								end
								TAG_UMIN: rmin_q <= data_q[15:0];
								TAG_UMAX: begin
									if (fill_q != '0) begin
										err_v_q <= 1'b1;
										err_q   <= ERR_RANGE;
									end else begin
										rv_q   <= {1'b0, rmin_q};
										rmax_q <= data_q[15:0];
									end
								end
								default: begin
									err_v_q <= 1'b1;
									err_q   <= ERR_LOCAL_TAG;
								end
							endcase
						end
						default: begin
							err_v_q <= 1'b1;
							err_q   <= ERR_RESERVED;
						end
					endcase
				end
				OP_POP: open_q <= parent_rd_q;
				OP_RANGE: begin
					if (!status.range_done) begin
						fill_q <= fill_q + UF_W'(1);
						rv_q   <= rv_q + 17'd1;
					end
				end
				OP_SRD: begin
					if (status.srch_end) begin
						if (status.rep_full) begin
							err_v_q <= 1'b1;
							err_q   <= ERR_REPORTS;
						end else begin
							offset_q   <= '0;
							ridx_q     <= si_q[RA_W-1:0];
							rep_used_q <= rep_used_q + RC_W'(1);
						end
					end
				end
				OP_SCMP: begin
					if (status.id_match) begin
						offset_q <= rep_rd_q[23:0];
						ridx_q   <= si_q[RA_W-1:0];
					end else begin
						si_q <= si_q + RC_W'(1);
					end
				end
				OP_MUL: prod_q <= 32'(size_q) * 32'(count_q);
				OP_ADD: begin
					if (fill_q == '0)
						rmin_q <= '0;
				end
				OP_HDR: begin
					ucnt_q       <= cnt;
					ui_q         <= '0;
					res_valid    <= 1'b1;
					result_kind  <= KIND_HEADER;
					rpt_id       <= rid_q;
					bit_offset   <= offset_q;
					field_size   <= size_q;
					field_count  <= count_q;
					logical_min  <= lim_q[0];
					logical_max  <= lim_q[1];
					physical_min <= lim_q[2];
					physical_max <= lim_q[3];
					unit_code    <= unit_q;
					usage        <= '0;
					last         <= 1'b0;
				end
				OP_URD: ;
				OP_UEM: begin
					res_valid    <= 1'b1;
					result_kind  <= KIND_USAGE;
					rpt_id       <= '0;
					bit_offset   <= '0;
					field_size   <= '0;
					field_count  <= '0;
					logical_min  <= '0;
					logical_max  <= '0;
					physical_min <= '0;
					physical_max <= '0;
					unit_code    <= '0;
					usage        <= usage_rd_q | {page_q, 8'd0};
					last         <= status.usg_last && !last_q;
					ui_q         <= ui_q + UF_W'(1);
					if (status.usg_last) begin
						fill_q <= '0;
						rmin_q <= '0;
					end
				end
				OP_FIN: begin
					err_v_q <= 1'b0;
					if (fin_err || last_q) begin
						res_valid    <= 1'b1;
						result_kind  <= err_v_q ? err_q : (fin_err ? ERR_TRUNC : KIND_DONE);
						rpt_id       <= '0;
						bit_offset   <= '0;
						field_size   <= '0;
						field_count  <= '0;
						logical_min  <= '0;
						logical_max  <= '0;
						physical_min <= '0;
						physical_max <= '0;
						unit_code    <= '0;
						usage        <= '0;
						last         <= 1'b1;
					end
					if (fin_err) begin
						err_latched_q <= 1'b1;
						phase_q       <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	`HRDP_ASSERT_IMP(a_fill_max, 1'b1, fill_q <= MAX_USAGES)
	`HRDP_ASSERT_IMP(a_tables_max, 1'b1, rep_used_q <= MAX_REPORTS && coll_used_q <= MAX_NESTING)
	`HRDP_ASSERT_NEXT(a_latch_hold, err_latched_q && cmd.op != OP_START, err_latched_q)

endmodule

[rtl/hrdp_ctrl.sv]
// Sequencer of the HID descriptor parser: steps one descriptor byte through
// decode, table walks and result transfers. Uses hrdp_pkg.
`include "hid_report_descriptor_parser_top_defines.svh"
module hrdp_ctrl
	import hrdp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    desc_valid,
	output logic    desc_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_START = 14'b00000000000010,
		S_BYTE  = 14'b00000000000100,
		S_EXEC  = 14'b00000000001000,
		S_POP   = 14'b00000000010000,
		S_RANGE = 14'b00000000100000,
		S_SRD   = 14'b00000001000000,
		S_SCMP  = 14'b00000010000000,
		S_MUL   = 14'b00000100000000,
		S_ADD   = 14'b00001000000000,
		S_HDR   = 14'b00010000000000,
		S_URD   = 14'b00100000000000,
		S_UEM   = 14'b01000000000000,
		S_FIN   = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign desc_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (desc_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				cmd.op  = OP_START;
				state_d = S_BYTE;
			end
			S_BYTE: begin
				cmd.op = OP_BYTE;
				priority if (status.latched)
					state_d = S_IDLE;
				else if (status.complete)
					state_d = S_EXEC;
				else
					state_d = S_FIN;
			end
			S_EXEC: begin
				cmd.op = OP_EXEC;
				unique case (status.exec_next)
					NX_POP:   state_d = S_POP;
					NX_SRCH:  state_d = S_SRD;
					NX_RANGE: state_d = S_RANGE;
					default:  state_d = S_FIN;
				endcase
			end
			S_POP: begin
				cmd.op  = OP_POP;
				state_d = S_FIN;
			end
			S_RANGE: begin
				cmd.op = OP_RANGE;
				if (status.range_done)
					state_d = S_FIN;
			end
			S_SRD: begin
				cmd.op = OP_SRD;
				priority if (status.srch_end && status.rep_full)
					state_d = S_FIN;
				else if (status.srch_end)
					state_d = S_MUL;
				else
					state_d = S_SCMP;
			end
			S_SCMP: begin
				cmd.op  = OP_SCMP;
				state_d = status.id_match ? S_MUL : S_SRD;
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.op  = OP_ADD;
				state_d = status.has_usages ? S_HDR : S_FIN;
			end
			S_HDR: begin
				if (status.out_free) begin
					cmd.op  = OP_HDR;
					state_d = S_URD;
				end
			end
			S_URD: begin
				cmd.op  = OP_URD;
				state_d = S_UEM;
			end
			S_UEM: begin
				if (status.out_free) begin
					cmd.op  = OP_UEM;
					state_d = status.usg_last ? S_FIN : S_URD;
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.op  = OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	`HRDP_ASSERT_NEXT(a_accept_start, desc_valid && !desc_stall, state_q == S_START)
	`HRDP_ASSERT_IMP(a_emit_free, cmd.op == OP_UEM || cmd.op == OP_HDR, status.out_free)

endmodule
